[rtl/pil_pkg.sv]
// Shared constants, types and codes of the positional insert/remove list.
package pil_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int INDEX_W  = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_APPEND  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_READ    = 3'd3,
        OP_REPLACE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_LOAD
    } cell_mode_t;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        status_t              status;
        logic [INDEX_W-1:0]   position;
        logic [WORD_W-1:0]    data;
        logic [COUNT_W-1:0]   count;
    } result_t;

endpackage

[rtl/positional_insert_remove_list.sv]
// Top level of the positional insert/remove list: cell row, decoder and result register.
//
// The block keeps an ordered list of up to DEPTH words in a row of cells.
// Each transaction on the s_ channel carries one operation: insert at a
// position, append, remove, read or replace. Every operation yields exactly
// one transaction on the m_ channel with the status, the position, the data
// word and the element count after the operation.
// An operation is decoded and applied to all cells in the cycle it is
// accepted, since every cell shifts or loads in parallel; its result is
// presented on the m_ channel in the next cycle.
// Throughput is one operation per cycle, set by the single result register:
// a new transaction is accepted whenever that register is empty or is being
// drained in the same cycle.
// When the receiver stalls, the result waits in the register and s_tready
// falls until it is taken.
// Reset empties the list and the result register; stored words are not
// cleared and only written entries are ever returned.
module positional_insert_remove_list (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op [2:0], index [7:3], value [39:8].
    input  logic [pil_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], position [6:2], data [38:7], count [43:39], zero [47:44].
    output logic [pil_pkg::M_TDATA_W-1:0]     m_tdata
);
    import pil_pkg::*;

    localparam int PAD_W = M_TDATA_W - STATUS_W - INDEX_W - WORD_W - COUNT_W;

    logic                  accept;
    logic [OP_W-1:0]       in_op;
    logic [INDEX_W-1:0]    in_index;
    value_t                in_word;

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    result_t               result_reg;
    result_t               result;

    value_t                cell_values [DEPTH];
    cell_mode_t            cell_modes  [DEPTH];

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_index = s_tdata[OP_W +: INDEX_W];
    assign in_word  = s_tdata[OP_W + INDEX_W +: VALUE_WIDTH];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    pil_ctrl u_ctrl (
        .accept      (accept),
        .op          (in_op),
        .index       (in_index),
        .count       (count_reg),
        .cell_values (cell_values),
        .cell_modes  (cell_modes),
        .count_next  (count_next),
        .result      (result)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        value_t left_value;
        value_t right_value;

        if (k == 0) begin : g_first
            assign left_value = cell_values[k];
        end else begin : g_left
            assign left_value = cell_values[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_value = cell_values[k];
        end else begin : g_right
            assign right_value = cell_values[k+1];
        end

        pil_cell u_cell (
            .aclk        (aclk),
            .mode        (cell_modes[k]),
            .word        (in_word),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_values[k])
        );
    end

    always_comb begin
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, result_reg.count, result_reg.data,
                       result_reg.position, result_reg.status};

endmodule

[rtl/pil_cell.sv]
// One storage cell of the list: holds, shifts from a neighbor, or loads a new word.
module pil_cell (
    input  logic                aclk,
    input  pil_pkg::cell_mode_t mode,
    input  pil_pkg::value_t     word,
    input  pil_pkg::value_t     left_value,
    input  pil_pkg::value_t     right_value,
    output pil_pkg::value_t     value
);
    import pil_pkg::*;

    value_t value_reg;
    value_t value_next;

    always_comb begin
        case (mode)
            CELL_HOLD:       value_next = value_reg;
            CELL_FROM_LEFT:  value_next = left_value;
            CELL_FROM_RIGHT: value_next = right_value;
            CELL_LOAD:       value_next = word;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/pil_ctrl.sv]
// Operation decoder: checks range and fill, steers every cell and forms the result.
module pil_ctrl (
    input  logic                              accept,
    input  logic [pil_pkg::OP_W-1:0]          op,
    input  logic [pil_pkg::INDEX_W-1:0]       index,
    input  logic [pil_pkg::COUNT_W-1:0]       count,
    input  pil_pkg::value_t                   cell_values [pil_pkg::DEPTH],
    output pil_pkg::cell_mode_t               cell_modes  [pil_pkg::DEPTH],
    output logic [pil_pkg::COUNT_W-1:0]       count_next,
    output pil_pkg::result_t                  result
);
    import pil_pkg::*;

    localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 full;
    logic                 in_range;
    logic                 do_place;
    logic                 do_remove;
    logic                 do_replace;
    logic [INDEX_W-1:0]   place_pos;
    value_t               picked;

    assign full     = (count >= COUNT_W'(DEPTH));
    assign in_range = (COUNT_W'(index) < count);
    assign picked   = cell_values[index[SEL_W-1:0]];

    always_comb begin
        do_place        = 1'b0;
        do_remove       = 1'b0;
        do_replace      = 1'b0;
        place_pos       = index;
        result.status   = ST_OK;
        result.position = index;
        result.data     = '0;
        case (op_t'(op))
            OP_INSERT: begin
                if (full) begin
                    result.status = ST_FULL;
                end else if (COUNT_W'(index) > count) begin
                    result.status = ST_RANGE;
                end else begin
                    do_place = 1'b1;
                end
            end
            OP_APPEND: begin
                place_pos       = INDEX_W'(count);
                result.position = INDEX_W'(count);
                if (full) begin
                    result.status = ST_FULL;
                end else begin
                    do_place = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (!in_range) begin
                    result.status = ST_RANGE;
                end else begin
                    do_remove   = 1'b1;
                    result.data = WORD_W'(picked);
                end
            end
            OP_READ: begin
                if (!in_range) begin
                    result.status = ST_RANGE;
                end else begin
                    result.data = WORD_W'(picked);
                end
            end
            OP_REPLACE: begin
                if (!in_range) begin
                    result.status = ST_RANGE;
                end else begin
                    do_replace  = 1'b1;
                    result.data = WORD_W'(picked);
                end
            end
            default: begin
                result.status = ST_RANGE;
            end
        endcase

        if (do_place) begin
            count_next = count + COUNT_W'(1);
        end else if (do_remove) begin
            count_next = count - COUNT_W'(1);
        end else begin
            count_next = count;
        end
        result.count = count_next;

        for (int k = 0; k < DEPTH; k++) begin
            cell_modes[k] = CELL_HOLD;
            if (accept) begin
                if (do_place) begin
                    if (INDEX_W'(k) > place_pos) begin
                        cell_modes[k] = CELL_FROM_LEFT;
                    end else if (INDEX_W'(k) == place_pos) begin
                        cell_modes[k] = CELL_LOAD;
                    end
                end else if (do_remove) begin
                    if (INDEX_W'(k) >= index) begin
                        cell_modes[k] = CELL_FROM_RIGHT;
                    end
                end else if (do_replace) begin
                    if (INDEX_W'(k) == index) begin
                        cell_modes[k] = CELL_LOAD;
                    end
                end
            end
        end
    end

endmodule
